@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checkers in this folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, disabled while reset is high.
`define GN_ASSERT_IMP(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("gradient noise check failed");

// Implication into the next cycle, disabled while reset is high.
`define GN_ASSERT_NXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("gradient noise check failed");

// Condition that must hold in the cycle after reset is seen.
`define GN_ASSERT_RST(label, clock, reset, cons) \
  label: assert property (@(posedge clock) (reset) |=> (cons)) \
    else $error("gradient noise reset check failed");

`endif

@@ rtl/core/gn2d_pkg.sv @@
// ----------------------------------------------------------------------------
// gn2d_pkg
// Shared widths, codes and control types of the gradient noise block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gn2d_pkg;

  // Default sizing of the gradient grid and of the coordinate format.
  localparam int GRID_COLS_MAX_DEF   = 64;
  localparam int GRID_ROWS_MAX_DEF   = 64;
  localparam int COORD_FRAC_BITS_DEF = 12;

  // Field widths of the transaction ports.
  localparam int CELL_W  = 6;
  localparam int GRAD_W  = 16;
  localparam int POS_W   = 18;
  localparam int NOISE_W = 16;

  // Configuration port.
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_W-1:0]     CFG_RESET        = 7'd64;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 1'b1;

  // Command codes.
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Smoothstep weight: 0..65536 with 16 fraction bits.
  localparam int WEIGHT_W    = 17;
  localparam int WEIGHT_FRAC = 16;

  // Corner dot products after rounding, and the working width of the blends.
  localparam int DOT_W = 18;
  localparam int VAL_W = 19;

  // Stage enables of the smoothstep unit.
  typedef struct packed {
    logic sq;
    logic mul;
    logic rnd;
  } wgt_en_t;

  // Stage enables of one blend unit.
  typedef struct packed {
    logic mul;
    logic add;
  } lerp_en_t;

endpackage

@@ rtl/core/gn2d_weight.sv @@
// ----------------------------------------------------------------------------
// gn2d_weight
// Three-stage smoothstep weight 3w^2 - 2w^3 of a coordinate fraction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gn2d_weight import gn2d_pkg::*; #(
  parameter int FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  wgt_en_t              en,
  input  logic [FRAC_BITS-1:0] frac,
  output logic [WEIGHT_W-1:0]  weight
);

  localparam int SQ_W  = 2 * FRAC_BITS;
  localparam int K_W   = FRAC_BITS + 2;
  localparam int S_W   = SQ_W + K_W;
  localparam int SHIFT = 3 * FRAC_BITS - WEIGHT_FRAC;
  localparam logic [K_W-1:0] THREE_ONE = K_W'(3 << FRAC_BITS);

  logic [SQ_W-1:0]     frac_sq;
  logic [K_W-1:0]      k_fac;
  logic [S_W-1:0]      prod;
  logic [WEIGHT_W-1:0] weight_raw;

  // The curve is written as f^2 * (3 - 2f), both factors formed first.
  always_ff @(posedge clk) begin
    if (en.sq) begin
      frac_sq <= SQ_W'(frac) * SQ_W'(frac);
      k_fac   <= THREE_ONE - K_W'({frac, 1'b0});
    end
  end

  // One product of the square and the linear factor.
  always_ff @(posedge clk) begin
    if (en.mul) begin
      prod <= S_W'(frac_sq) * S_W'(k_fac);
    end
  end

  // Bring the product to 16 fraction bits, rounding half up when narrowing.
  generate
    if (SHIFT > 0) begin : g_round
      localparam logic [S_W-1:0] HALF = S_W'(1) << (SHIFT - 1);
      assign weight_raw = WEIGHT_W'((prod + HALF) >> SHIFT);
    end else begin : g_scale
      assign weight_raw = WEIGHT_W'({prod, {(-SHIFT){1'b0}}});
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en.rnd) begin
      weight <= weight_raw;
    end
  end

endmodule

@@ rtl/core/gn2d_lerp.sv @@
// ----------------------------------------------------------------------------
// gn2d_lerp
// Two-stage blend a0 + round((a1 - a0) * s / 2^16).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gn2d_lerp import gn2d_pkg::*; #(
  parameter int VAL_WIDTH = VAL_W
) (
  input  logic                        clk,
  input  lerp_en_t                    en,
  input  logic signed [VAL_WIDTH-1:0] a0,
  input  logic signed [VAL_WIDTH-1:0] a1,
  input  logic        [WEIGHT_W-1:0]  weight,
  output logic signed [VAL_WIDTH-1:0] result
);

  localparam int DIFF_W = VAL_WIDTH + 1;
  localparam int PROD_W = DIFF_W + WEIGHT_W + 1;
  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(2 ** (WEIGHT_FRAC - 1));

  logic signed [DIFF_W-1:0]    diff;
  logic signed [WEIGHT_W:0]    weight_s;
  logic signed [PROD_W-1:0]    prod;
  logic signed [PROD_W-1:0]    rounded;
  logic signed [VAL_WIDTH-1:0] a0_q;

  assign diff     = DIFF_W'(a1) - DIFF_W'(a0);
  assign weight_s = {1'b0, weight};

  // Scale the difference by the weight; keep a0 alongside.
  always_ff @(posedge clk) begin
    if (en.mul) begin
      a0_q <= a0;
      prod <= PROD_W'(diff) * PROD_W'(weight_s);
    end
  end

  // Round half up and add back the start point.
  assign rounded = (prod + HALF) >>> WEIGHT_FRAC;

  always_ff @(posedge clk) begin
    if (en.add) begin
      result <= VAL_WIDTH'(rounded + PROD_W'(a0_q));
    end
  end

endmodule

@@ rtl/core/gradient_noise_2d.sv @@
// ----------------------------------------------------------------------------
// gradient_noise_2d
// 2D gradient noise from a stored grid of gradient vectors.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock, write or sample, while in_stall
// is low, and delivers a result for each sample; a write gives
// no result. The rate is set by the gradient store, which is
// split into four banks by column and row parity so that the four corners of
// a cell are read together, one read per bank, while a write takes the
// single write port of its bank in the same pipeline stage. Writes and samples
// reach the store in acceptance order, so a sample sees every earlier write.
// The store is not cleared: a sample must only touch cells written before it.
// Grid size registers may be changed only while no transaction is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gradient_noise_2d import gn2d_pkg::*; #(
  parameter int GRID_COLS_MAX   = GRID_COLS_MAX_DEF,
  parameter int GRID_ROWS_MAX   = GRID_ROWS_MAX_DEF,
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // Configuration writes.
  input  logic                       cfg_write,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  // Input transactions.
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       cmd,
  input  logic [CELL_W-1:0]          cell_col,
  input  logic [CELL_W-1:0]          cell_row,
  input  logic signed [GRAD_W-1:0]   grad_x,
  input  logic signed [GRAD_W-1:0]   grad_y,
  input  logic [POS_W-1:0]           pos_x,
  input  logic [POS_W-1:0]           pos_y,
  // Result transactions.
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [NOISE_W-1:0]  noise_value,
  output logic                       out_of_range
);

  localparam int FRAC       = COORD_FRAC_BITS;
  localparam int CELLX_W    = POS_W - FRAC;
  localparam int BANK_COLS  = (GRID_COLS_MAX + 1) / 2;
  localparam int BANK_ROWS  = (GRID_ROWS_MAX + 1) / 2;
  localparam int CB         = (BANK_COLS > 1) ? $clog2(BANK_COLS) : 1;
  localparam int RB         = (BANK_ROWS > 1) ? $clog2(BANK_ROWS) : 1;
  localparam int ADDR_W     = CB + RB;
  localparam int BANK_DEPTH = 1 << ADDR_W;
  localparam int CMP_W      = 16;
  localparam int NUM_STAGES = 9;
  localparam int DOT_PW     = FRAC + 1 + GRAD_W;
  localparam int DOT_SW     = DOT_PW + 1;
  localparam logic signed [DOT_SW-1:0] DOT_HALF = DOT_SW'(2 ** (FRAC - 1));
  localparam logic signed [VAL_W-1:0]  SAT_HI   = VAL_W'(2 ** (NOISE_W - 1) - 1);
  localparam logic signed [VAL_W-1:0]  SAT_LO   = -VAL_W'(2 ** (NOISE_W - 1));

  // Configuration registers.
  logic [CFG_W-1:0] grid_columns;
  logic [CFG_W-1:0] grid_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns <= CFG_RESET;
      grid_rows    <= CFG_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_GRID_COLUMNS: grid_columns <= cfg_data;
        REG_GRID_ROWS:    grid_rows    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline flow control: a stage loads when it is empty or moves on.
  logic [NUM_STAGES:1]   stage_valid;
  logic [NUM_STAGES+1:1] load;

  assign load[NUM_STAGES+1] = !out_stall;

  generate
    for (genvar k = 1; k <= NUM_STAGES; k++) begin : g_load
      assign load[k] = !stage_valid[k] || load[k+1];
    end
  endgenerate

  assign in_stall  = !load[1];
  assign out_valid = stage_valid[NUM_STAGES];

  logic s1_cmd;

  // Valid bits; a write transaction leaves the pipeline at the store.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (load[1]) begin
        stage_valid[1] <= in_valid;
      end
      if (load[2]) begin
        stage_valid[2] <= stage_valid[1] && (s1_cmd == CMD_SAMPLE);
      end
      for (int k = 3; k <= NUM_STAGES; k++) begin
        if (load[k]) begin
          stage_valid[k] <= stage_valid[k-1];
        end
      end
    end
  end

  // Stage 1 decode: cell, fraction, range check and bank addresses.
  logic [CELLX_W-1:0] x0;
  logic [CELLX_W-1:0] y0;
  logic [CMP_W-1:0]   cols_eff;
  logic [CMP_W-1:0]   rows_eff;
  logic               oor_in;
  logic               wok_in;
  logic [CB-1:0]      col_even;
  logic [CB-1:0]      col_odd;
  logic [RB-1:0]      row_even;
  logic [RB-1:0]      row_odd;

  assign x0 = pos_x[POS_W-1:FRAC];
  assign y0 = pos_y[POS_W-1:FRAC];

  always_comb begin
    cols_eff = (CMP_W'(grid_columns) < CMP_W'(GRID_COLS_MAX)) ?
               CMP_W'(grid_columns) : CMP_W'(GRID_COLS_MAX);
    rows_eff = (CMP_W'(grid_rows) < CMP_W'(GRID_ROWS_MAX)) ?
               CMP_W'(grid_rows) : CMP_W'(GRID_ROWS_MAX);
  end

  assign oor_in = (CMP_W'(x0) + CMP_W'(1) >= cols_eff) ||
                  (CMP_W'(y0) + CMP_W'(1) >= rows_eff);
  assign wok_in = (CMP_W'(cell_col) < CMP_W'(GRID_COLS_MAX)) &&
                  (CMP_W'(cell_row) < CMP_W'(GRID_ROWS_MAX));

  // The even bank holds the corner at x0 when x0 is even, else x0 + 1.
  assign col_even = CB'((x0 >> 1) + CELLX_W'(x0[0]));
  assign col_odd  = CB'(x0 >> 1);
  assign row_even = RB'((y0 >> 1) + CELLX_W'(y0[0]));
  assign row_odd  = RB'(y0 >> 1);

  logic                  s1_wok;
  logic [1:0]            s1_wbank;
  logic [ADDR_W-1:0]     s1_waddr;
  logic [2*GRAD_W-1:0]   s1_wdata;
  logic [ADDR_W-1:0]     s1_raddr [4];
  logic [FRAC-1:0]       s1_fx;
  logic [FRAC-1:0]       s1_fy;
  logic [1:0]            s1_par;
  logic [NUM_STAGES-1:1] oor_pipe;

  always_ff @(posedge clk) begin
    if (load[1]) begin
      s1_cmd      <= cmd;
      s1_wok      <= wok_in;
      s1_wbank    <= {cell_row[0], cell_col[0]};
      s1_waddr    <= {RB'(cell_row >> 1), CB'(cell_col >> 1)};
      s1_wdata    <= {grad_y, grad_x};
      s1_raddr[0] <= {row_even, col_even};
      s1_raddr[1] <= {row_even, col_odd};
      s1_raddr[2] <= {row_odd, col_even};
      s1_raddr[3] <= {row_odd, col_odd};
      s1_fx       <= pos_x[FRAC-1:0];
      s1_fy       <= pos_y[FRAC-1:0];
      s1_par      <= {y0[0], x0[0]};
    end
  end

  // The out-of-range flag enters with the item and travels with it.
  always_ff @(posedge clk) begin
    if (load[1]) begin
      oor_pipe[1] <= oor_in;
    end
    for (int k = 2; k < NUM_STAGES; k++) begin
      if (load[k]) begin
        oor_pipe[k] <= oor_pipe[k-1];
      end
    end
  end

  // Stage 2: gradient store banks, one read and at most one write per bank.
  logic [2*GRAD_W-1:0] bank_rd [4];

  generate
    for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [2*GRAD_W-1:0] mem [BANK_DEPTH];

      always_ff @(posedge clk) begin
        if (load[2]) begin
          if (stage_valid[1] && (s1_cmd == CMD_WRITE) && s1_wok &&
              (s1_wbank == 2'(b))) begin
            mem[s1_waddr] <= s1_wdata;
          end
          bank_rd[b] <= mem[s1_raddr[b]];
        end
      end
    end
  endgenerate

  logic [FRAC-1:0] s2_fx;
  logic [FRAC-1:0] s2_fy;
  logic [1:0]      s2_par;

  always_ff @(posedge clk) begin
    if (load[2]) begin
      s2_fx  <= s1_fx;
      s2_fy  <= s1_fy;
      s2_par <= s1_par;
    end
  end

  // Smoothstep weights, ready in stage 4.
  logic [WEIGHT_W-1:0] sx;
  logic [WEIGHT_W-1:0] sy;
  wgt_en_t             wgt_en;

  assign wgt_en = '{sq: load[2], mul: load[3], rnd: load[4]};

  gn2d_weight #(.FRAC_BITS(FRAC)) u_weight_x (
    .clk    (clk),
    .en     (wgt_en),
    .frac   (s1_fx),
    .weight (sx)
  );

  gn2d_weight #(.FRAC_BITS(FRAC)) u_weight_y (
    .clk    (clk),
    .en     (wgt_en),
    .frac   (s1_fy),
    .weight (sy)
  );

  // Stage 3: route banks to corners and form the offset products.
  // Corner k has bit 0 set for column x0 + 1 and bit 1 for row y0 + 1.
  logic signed [FRAC:0]     dx [4];
  logic signed [FRAC:0]     dy [4];
  logic [2*GRAD_W-1:0]      grad_sel [4];
  logic signed [DOT_PW-1:0] prod_x [4];
  logic signed [DOT_PW-1:0] prod_y [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      dx[k]       = {k[0], s2_fx};
      dy[k]       = {k[1], s2_fy};
      grad_sel[k] = bank_rd[2'(k) ^ s2_par];
    end
  end

  always_ff @(posedge clk) begin
    if (load[3]) begin
      for (int k = 0; k < 4; k++) begin
        prod_x[k] <= DOT_PW'(dx[k]) * DOT_PW'($signed(grad_sel[k][GRAD_W-1:0]));
        prod_y[k] <= DOT_PW'(dy[k]) * DOT_PW'($signed(grad_sel[k][2*GRAD_W-1:GRAD_W]));
      end
    end
  end

  // Stage 4: sum and round each dot product to Q3.14.
  logic signed [DOT_SW-1:0] dot_sum [4];
  logic signed [DOT_W-1:0]  corner_n [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      dot_sum[k] = DOT_SW'(prod_x[k]) + DOT_SW'(prod_y[k]) + DOT_HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (load[4]) begin
      for (int k = 0; k < 4; k++) begin
        corner_n[k] <= DOT_W'(dot_sum[k] >>> FRAC);
      end
    end
  end

  // Stages 5 and 6: blend along x for both rows.
  lerp_en_t            lerp_x_en;
  lerp_en_t            lerp_y_en;
  logic signed [VAL_W-1:0] r0;
  logic signed [VAL_W-1:0] r1;
  logic signed [VAL_W-1:0] v8;
  logic [WEIGHT_W-1:0] s5_sy;
  logic [WEIGHT_W-1:0] s6_sy;

  assign lerp_x_en = '{mul: load[5], add: load[6]};
  assign lerp_y_en = '{mul: load[7], add: load[8]};

  gn2d_lerp #(.VAL_WIDTH(VAL_W)) u_lerp_row0 (
    .clk    (clk),
    .en     (lerp_x_en),
    .a0     (VAL_W'(corner_n[0])),
    .a1     (VAL_W'(corner_n[1])),
    .weight (sx),
    .result (r0)
  );

  gn2d_lerp #(.VAL_WIDTH(VAL_W)) u_lerp_row1 (
    .clk    (clk),
    .en     (lerp_x_en),
    .a0     (VAL_W'(corner_n[2])),
    .a1     (VAL_W'(corner_n[3])),
    .weight (sx),
    .result (r1)
  );

  // The y weight waits beside the x blends.
  always_ff @(posedge clk) begin
    if (load[5]) begin
      s5_sy <= sy;
    end
    if (load[6]) begin
      s6_sy <= s5_sy;
    end
  end

  // Stages 7 and 8: blend the two rows along y.
  gn2d_lerp #(.VAL_WIDTH(VAL_W)) u_lerp_col (
    .clk    (clk),
    .en     (lerp_y_en),
    .a0     (r0),
    .a1     (r1),
    .weight (s6_sy),
    .result (v8)
  );

  // Stage 9: saturate, or force zero for a point off the grid.
  logic signed [NOISE_W-1:0] noise_sat;

  always_comb begin
    if (v8 > SAT_HI) begin
      noise_sat = NOISE_W'(SAT_HI);
    end else if (v8 < SAT_LO) begin
      noise_sat = NOISE_W'(SAT_LO);
    end else begin
      noise_sat = NOISE_W'(v8);
    end
  end

  always_ff @(posedge clk) begin
    if (load[NUM_STAGES]) begin
      noise_value  <= oor_pipe[NUM_STAGES-1] ? '0 : noise_sat;
      out_of_range <= oor_pipe[NUM_STAGES-1];
    end
  end

endmodule

@@ rtl/core/gn2d_checker.sv @@
// ----------------------------------------------------------------------------
// gn2d_checker
// Port-level checks of the gradient noise block, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gn2d_checker import gn2d_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic signed [NOISE_W-1:0] noise_value,
  input logic                      out_of_range
);

  // A point off the grid always reads as zero.
  `GN_ASSERT_IMP(a_oor_zero, clk, rst, out_valid && out_of_range, noise_value == '0)

  // The input side backs up only when the pipeline is full and the output waits.
  `GN_ASSERT_IMP(a_stall_when_full, clk, rst, in_stall, out_valid && out_stall)

  // A waiting result transaction holds its payload.
  `GN_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(noise_value) && $stable(out_of_range))

  // Reset empties the pipeline.
  `GN_ASSERT_RST(a_reset_empty, clk, rst, !out_valid)

endmodule

bind gradient_noise_2d gn2d_checker u_gn2d_checker (.*);

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 2D gradient noise block. Gradient writes and
// noise samples are driven through the valid/stall input channel, and every
// sample result is compared with a bit-exact fixed-point predictor kept here.
// Directed corner cases, several grid sizes, back-to-back traffic, a long
// output hold and a random phase are run in turn.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import gn2d_pkg::*;

  localparam int FRAC       = COORD_FRAC_BITS_DEF;
  localparam int ONE        = 1 << FRAC;
  localparam int COLS_MAX   = GRID_COLS_MAX_DEF;
  localparam int ROWS_MAX   = GRID_ROWS_MAX_DEF;
  localparam int DRAIN      = 16;
  localparam int QUIET_MAX  = 5000;
  localparam int PRINT_MAX  = 40;

  typedef struct packed {
    logic                      cmd;
    logic [CELL_W-1:0]         col;
    logic [CELL_W-1:0]         row;
    logic signed [GRAD_W-1:0]  gx;
    logic signed [GRAD_W-1:0]  gy;
    logic [POS_W-1:0]          px;
    logic [POS_W-1:0]          py;
  } noise_item_t;

  typedef struct packed {
    logic signed [NOISE_W-1:0] noise;
    logic                      oor;
  } noise_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_GRID_COLUMNS;
  logic [CFG_W-1:0] cfg_data = CFG_RESET;
  logic in_valid = 1'b0;
  logic in_stall;
  logic cmd = CMD_WRITE;
  logic [CELL_W-1:0] cell_col = '0;
  logic [CELL_W-1:0] cell_row = '0;
  logic signed [GRAD_W-1:0] grad_x = '0;
  logic signed [GRAD_W-1:0] grad_y = '0;
  logic [POS_W-1:0] pos_x = '0;
  logic [POS_W-1:0] pos_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [NOISE_W-1:0] noise_value;
  logic out_of_range;

  // Local copy of the grid state and registers.
  logic [31:0] grad_mem [0:COLS_MAX*ROWS_MAX-1];
  bit grad_written [0:COLS_MAX*ROWS_MAX-1];
  logic [CFG_W-1:0] grid_cols_cfg = CFG_RESET;
  logic [CFG_W-1:0] grid_rows_cfg = CFG_RESET;

  noise_result_t pending_noise [$];
  int mismatches = 0;
  int quiet_cycles = 0;
  int hold_req = 0;
  int hold_left = 0;
  int stall_left = 0;
  bit in_gaps_on = 1'b1;
  bit out_stalls_on = 1'b1;

  gradient_noise_2d i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .cell_col     (cell_col),
    .cell_row     (cell_row),
    .grad_x       (grad_x),
    .grad_y       (grad_y),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .noise_value  (noise_value),
    .out_of_range (out_of_range)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point predictor
  // ---------------------------------------------------------------------------

  // Divide by 2^k, rounding half toward positive infinity.
  function automatic longint round_div(longint v, int k);
    return (v + (longint'(1) << (k - 1))) >>> k;
  endfunction

  function automatic int cols_in_use();
    return (grid_cols_cfg < COLS_MAX) ? int'(grid_cols_cfg) : COLS_MAX;
  endfunction

  function automatic int rows_in_use();
    return (grid_rows_cfg < ROWS_MAX) ? int'(grid_rows_cfg) : ROWS_MAX;
  endfunction

  // Dot product of one corner gradient with the offset to the point, in Q3.14.
  function automatic longint corner_dot(int col, int row, longint dx, longint dy);
    logic [31:0] e;
    longint gx;
    longint gy;
    e = grad_mem[row * COLS_MAX + col];
    gx = $signed(e[15:0]);
    gy = $signed(e[31:16]);
    return round_div(dx * gx + dy * gy, FRAC);
  endfunction

  // Smoothstep 3w^2 - 2w^3 scaled to 16 fraction bits.
  function automatic longint smooth_weight(longint f);
    longint s;
    s = 3 * f * f * ONE - 2 * f * f * f;
    return round_div(s, 3 * FRAC - WEIGHT_FRAC);
  endfunction

  function automatic longint blend(longint a0, longint a1, longint s);
    return a0 + round_div((a1 - a0) * s, WEIGHT_FRAC);
  endfunction

  function automatic noise_result_t noise_at(logic [POS_W-1:0] px, logic [POS_W-1:0] py);
    noise_result_t res;
    int x0;
    int y0;
    longint fx, fy, sx, sy, n00, n10, n01, n11, r0, r1, v;
    x0 = px >> FRAC;
    y0 = py >> FRAC;
    res.noise = '0;
    res.oor = 1'b1;
    if (x0 + 1 >= cols_in_use() || y0 + 1 >= rows_in_use()) begin
      return res;
    end
    fx = px & (ONE - 1);
    fy = py & (ONE - 1);
    n00 = corner_dot(x0, y0, fx, fy);
    n10 = corner_dot(x0 + 1, y0, fx - ONE, fy);
    n01 = corner_dot(x0, y0 + 1, fx, fy - ONE);
    n11 = corner_dot(x0 + 1, y0 + 1, fx - ONE, fy - ONE);
    sx = smooth_weight(fx);
    sy = smooth_weight(fy);
    r0 = blend(n00, n10, sx);
    r1 = blend(n01, n11, sx);
    v = blend(r0, r1, sy);
    if (v > 32767) begin
      v = 32767;
    end
    if (v < -32768) begin
      v = -32768;
    end
    res.noise = v[NOISE_W-1:0];
    res.oor = 1'b0;
    return res;
  endfunction

  // Update the local state for one accepted transaction.
  task automatic apply_item(noise_item_t it);
    int idx;
    idx = it.row * COLS_MAX + it.col;
    if (it.cmd == CMD_WRITE) begin
      grad_mem[idx] = {it.gy, it.gx};
      grad_written[idx] = 1'b1;
    end else begin
      pending_noise.push_back(noise_at(it.px, it.py));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------------

  // Idle length: mostly none, often short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [GRAD_W-1:0] rand_grad();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'sd0;
      default: return GRAD_W'(int'($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic int rand_frac();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 0;
      1: return ONE - 1;
      2: return ONE / 2;
      default: return $urandom_range(0, ONE - 1);
    endcase
  endfunction

  // Grid size register value, with the values outside the nominal range too.
  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return $urandom_range(0, 1);
      1: return $urandom_range(65, 127);
      2: return 2;
      3: return 64;
      default: return $urandom_range(2, 64);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Offer one transaction and wait until the block takes it.
  task automatic send_item(noise_item_t it);
    int gap;
    gap = in_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    cmd      <= it.cmd;
    cell_col <= it.col;
    cell_row <= it.row;
    grad_x   <= it.gx;
    grad_y   <= it.gy;
    pos_x    <= it.px;
    pos_y    <= it.py;
    do @(posedge clk); while (in_stall);
    apply_item(it);
  endtask

  task automatic write_gradient(int col, int row, logic signed [GRAD_W-1:0] gx,
                                logic signed [GRAD_W-1:0] gy);
    noise_item_t it;
    it.cmd = CMD_WRITE;
    it.col = CELL_W'(col);
    it.row = CELL_W'(row);
    it.gx  = gx;
    it.gy  = gy;
    it.px  = POS_W'($urandom_range(0, (1 << POS_W) - 1));
    it.py  = POS_W'($urandom_range(0, (1 << POS_W) - 1));
    send_item(it);
  endtask

  task automatic sample_at(int px, int py);
    noise_item_t it;
    it.cmd = CMD_SAMPLE;
    it.col = CELL_W'($urandom_range(0, 63));
    it.row = CELL_W'($urandom_range(0, 63));
    it.gx  = GRAD_W'($urandom_range(0, 65535));
    it.gy  = GRAD_W'($urandom_range(0, 65535));
    it.px  = POS_W'(px);
    it.py  = POS_W'(py);
    send_item(it);
  endtask

  // Write any corner of a cell that has not been written yet.
  task automatic prepare_cell(int cx, int cy);
    int dc;
    int dr;
    for (dr = 0; dr < 2; dr++) begin
      for (dc = 0; dc < 2; dc++) begin
        if (!grad_written[(cy + dr) * COLS_MAX + cx + dc]) begin
          write_gradient(cx + dc, cy + dr, rand_grad(), rand_grad());
        end
      end
    end
  endtask

  task automatic sample_outside();
    int cx;
    int cy;
    int lo;
    cx = $urandom_range(0, 63);
    cy = $urandom_range(0, 63);
    if ($urandom_range(0, 1)) begin
      lo = (cols_in_use() > 0) ? cols_in_use() - 1 : 0;
      cx = $urandom_range(lo, 63);
    end else begin
      lo = (rows_in_use() > 0) ? rows_in_use() - 1 : 0;
      cy = $urandom_range(lo, 63);
    end
    sample_at(cx * ONE + rand_frac(), cy * ONE + rand_frac());
  endtask

  task automatic sample_inside();
    int cx;
    int cy;
    if (cols_in_use() < 2 || rows_in_use() < 2) begin
      sample_outside();
      return;
    end
    cx = $urandom_range(0, cols_in_use() - 2);
    cy = $urandom_range(0, rows_in_use() - 2);
    prepare_cell(cx, cy);
    sample_at(cx * ONE + rand_frac(), cy * ONE + rand_frac());
  endtask

  // Stop offering, wait for every result, then let in-flight writes settle.
  task automatic wait_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_noise.size() > 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic set_grid(int cols, int rows);
    wait_quiet();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_GRID_COLUMNS;
    cfg_data  <= CFG_W'(cols);
    @(negedge clk);
    cfg_index <= REG_GRID_ROWS;
    cfg_data  <= CFG_W'(rows);
    @(negedge clk);
    cfg_write <= 1'b0;
    grid_cols_cfg = CFG_W'(cols);
    grid_rows_cfg = CFG_W'(rows);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Extreme gradients and fractions at both ends of the reset-size grid.
  task automatic test_directed();
    int far;
    far = 62 * ONE;
    write_gradient(0, 0, 16'sd16384, 16'sd0);
    write_gradient(1, 0, -16'sd16384, 16'sd0);
    write_gradient(0, 1, 16'sd0, 16'sd16384);
    write_gradient(1, 1, 16'sd0, -16'sd16384);
    sample_at(0, 0);
    sample_at(ONE - 1, ONE - 1);
    sample_at(ONE / 2, ONE / 2);
    sample_at(ONE - 1, 0);
    sample_at(0, ONE - 1);
    write_gradient(62, 62, 16'sd16384, 16'sd16384);
    write_gradient(63, 62, -16'sd16384, -16'sd16384);
    write_gradient(62, 63, 16'sd16384, -16'sd16384);
    write_gradient(63, 63, -16'sd16384, 16'sd16384);
    sample_at(far + ONE - 1, far + ONE - 1);
    sample_at(far, far + ONE / 2);
    // Points whose cell touches the last column or row are flagged.
    sample_at((1 << POS_W) - 1, (1 << POS_W) - 1);
    sample_at(63 * ONE, 0);
    sample_at(0, 63 * ONE);
    sample_at(far + ONE - 1, (1 << POS_W) - 1);
  endtask

  // Grid sizes at and beyond the limits; sizes below two flag every sample.
  task automatic test_grid_sizes();
    int sizes [16];
    int k;
    int n;
    sizes = '{2, 2, 0, 1, 1, 0, 127, 127, 64, 2, 2, 64, 65, 3, 17, 33};
    for (k = 0; k < 16; k += 2) begin
      set_grid(sizes[k], sizes[k + 1]);
      for (n = 0; n < 4; n++) begin
        sample_inside();
      end
      sample_outside();
      sample_outside();
      write_gradient($urandom_range(0, 63), $urandom_range(0, 63), rand_grad(), rand_grad());
    end
  endtask

  // Full-rate traffic with no idling on either side.
  task automatic test_back_to_back();
    int k;
    set_grid(64, 64);
    in_gaps_on = 1'b0;
    out_stalls_on = 1'b0;
    for (k = 0; k < 40; k++) begin
      if (k % 4 == 0) begin
        write_gradient($urandom_range(0, 63), $urandom_range(0, 63), rand_grad(), rand_grad());
      end else begin
        sample_inside();
      end
    end
    in_gaps_on = 1'b1;
    out_stalls_on = 1'b1;
  endtask

  // Hold the output for a long stretch while samples keep coming.
  task automatic test_pressure();
    int k;
    set_grid(64, 64);
    prepare_cell(5, 9);
    in_gaps_on = 1'b0;
    hold_req = 300;
    for (k = 0; k < 100; k++) begin
      sample_at(5 * ONE + rand_frac(), 9 * ONE + rand_frac());
    end
    in_gaps_on = 1'b1;
  endtask

  // Mostly well-formed samples over random grid sizes, with random writes.
  task automatic test_random();
    int k;
    int r;
    for (k = 0; k < 80; k++) begin
      if (k % 20 == 0) begin
        set_grid(pick_size(), pick_size());
      end
      r = $urandom_range(0, 99);
      if (r < 25) begin
        write_gradient($urandom_range(0, 63), $urandom_range(0, 63), rand_grad(), rand_grad());
      end else if (r < 85) begin
        sample_inside();
      end else begin
        sample_outside();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= PRINT_MAX) begin
      $display("%0t ns: mismatch: %s", $time, msg);
    end
  endtask

  // Random output stalls, plus the long hold requested by the pressure test.
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!out_stalls_on) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_left = pick_gap();
      out_stall <= (stall_left > 0);
      if (stall_left > 0) begin
        stall_left--;
      end
    end
  end

  // Compare each result transaction with the oldest pending sample.
  always @(posedge clk) begin
    noise_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_noise.size() == 0) begin
        report_mismatch("result transaction with no sample pending");
      end else begin
        want = pending_noise.pop_front();
        if (noise_value !== want.noise) begin
          report_mismatch($sformatf("noise_value %0d, expected %0d", noise_value, want.noise));
        end
        if (out_of_range !== want.oor) begin
          report_mismatch($sformatf("out_of_range %b, expected %b", out_of_range, want.oor));
        end
      end
    end
  end

  // End the run if no transaction moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_MAX) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_grid_sizes();
    test_back_to_back();
    test_pressure();
    test_random();
    wait_quiet();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
